// ----- design/lmtf_pkg.sv -----
// ----------------------------------------------------------------------------
// lmtf_pkg
// shared types and codes of the move-to-front table: opcodes, per-cell
// commands and the entry record handed between neighboring cells
// ----------------------------------------------------------------------------
package lmtf_pkg;

  localparam int KeyW    = 32;
  localparam int HandleW = 32;
  localparam int OccW    = 5;

  localparam logic [1:0] OP_ADD        = 2'd0;
  localparam logic [1:0] OP_LOOKUP     = 2'd1;
  localparam logic [1:0] OP_INVALIDATE = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_TO_FRONT,
    CMD_REMOVE
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic cmp_en;
    cmd_e cmd;
  } cell_ctrl_t;

endpackage

// ----- design/lmtf_cell.sv -----
// ----------------------------------------------------------------------------
// lmtf_cell
// one slot of the recency list: holds an entry, compares its key against
// the request and moves data toward or away from the front on command
// ----------------------------------------------------------------------------
module lmtf_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lmtf_pkg::cell_ctrl_t        ctrl_i,
  input  logic [lmtf_pkg::KeyW-1:0]   cmp_key_i,
  input  logic                        seen_i,
  output logic                        seen_o,
  input  lmtf_pkg::entry_t            prev_i,
  input  lmtf_pkg::entry_t            next_i,
  input  logic [lmtf_pkg::HandleW-1:0] sel_handle_i,
  output logic [lmtf_pkg::HandleW-1:0] sel_handle_o,
  output lmtf_pkg::entry_t            entry_o,
  output logic                        match_o
);
  import lmtf_pkg::*;

  logic               valid_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] handle_q;
  entry_t             cur_entry, entry_d;
  logic               match_q, match_d;
  logic               seen_q;

  assign cur_entry = {valid_q, key_q, handle_q};

  always_comb begin
    match_d = cur_entry.valid && (cur_entry.key == cmp_key_i);
    seen_o  = seen_i | match_d;
  end

  // only the cell holding the matching key adds its handle
  assign sel_handle_o = sel_handle_i | (match_q ? cur_entry.handle : '0);

  always_comb begin
    entry_d = cur_entry;
    case (ctrl_i.cmd)
      CMD_INSERT: begin
        entry_d = prev_i;
      end
      CMD_TO_FRONT: begin
        // cells up to and including the hit shift one place back
        if (!seen_q) begin
          entry_d = prev_i;
        end
      end
      CMD_REMOVE: begin
        // the hit and everything behind it close up the gap
        if (seen_q || match_q) begin
          entry_d = next_i;
        end
      end
      default: begin
        entry_d = cur_entry;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
      if (ctrl_i.cmp_en) begin
        match_q <= match_d;
        seen_q  <= seen_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= entry_d.key;
    handle_q <= entry_d.handle;
  end

  assign entry_o = cur_entry;
  assign match_o = match_q;

endmodule

// ----- design/lru_move_to_front_table_unit.sv -----
// ----------------------------------------------------------------------------
// lru_move_to_front_table_unit
// recency-ordered key/handle table built as a chain of slot cells
// ----------------------------------------------------------------------------
// usage:
//   a request (opcode_i, key_i, handle_i) is taken at a rising edge with
//   start_i high and busy_o low. all cells compare the key in that same
//   edge; the next cycle applies the shift (insert, move to front or
//   remove) across the chain and registers the result.
//   the result appears in the following cycle, on hit_o, found_handle_o,
//   released_valid_o, released_handle_o and occupancy_o, marked by
//   result_valid_o for exactly one cycle. the receiver cannot stall.
//   busy_o is high for the one shift cycle after each request, and a new
//   request may be taken in the cycle its predecessor's result is shown.
//   the matched handle is or-ed along the cell chain, only the hit cell
//   adds to it, so the select is a linear or chain through the cells.
//   reset clears the valid bits and the entry count; the table starts
//   empty, with no clearing pass.
// ----------------------------------------------------------------------------
module lru_move_to_front_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    opcode_i,
  input  logic [lmtf_pkg::KeyW-1:0]     key_i,
  input  logic [lmtf_pkg::HandleW-1:0]  handle_i,
  output logic                          result_valid_o,
  output logic                          hit_o,
  output logic [lmtf_pkg::HandleW-1:0]  found_handle_o,
  output logic                          released_valid_o,
  output logic [lmtf_pkg::HandleW-1:0]  released_handle_o,
  output logic [lmtf_pkg::OccW-1:0]     occupancy_o
);
  import lmtf_pkg::*;

  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_DEPTH);

  state_e state_q, state_d;
  logic   accept;
  logic   shifting;

  logic [1:0]         op_q;
  logic [KeyW-1:0]    key_q;
  logic [HandleW-1:0] handle_q;
  logic [CntW-1:0]    live_q, live_d;

  logic               res_valid_q;
  logic               hit_q, hit_d;
  logic [HandleW-1:0] found_q, found_d;
  logic               rel_valid_q, rel_valid_d;
  logic [HandleW-1:0] rel_handle_q, rel_handle_d;

  cell_ctrl_t ctrl;
  cmd_e       cmd;
  entry_t     front;

  entry_t             cell_entry [TABLE_DEPTH];
  entry_t             cell_prev  [TABLE_DEPTH];
  entry_t             cell_next  [TABLE_DEPTH];
  logic [TABLE_DEPTH:0]  seen_chain;
  logic [HandleW-1:0]    sel_chain [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] valid_vec;

  logic               hit;
  logic               full;
  logic [HandleW-1:0] sel_handle;

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o   = 1'b0;
    shifting = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_SHIFT: begin
        busy_o   = 1'b1;
        shifting = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      res_valid_q <= shifting;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= opcode_i;
      key_q    <= key_i;
      handle_q <= handle_i;
    end
    if (shifting) begin
      hit_q        <= hit_d;
      found_q      <= found_d;
      rel_valid_q  <= rel_valid_d;
      rel_handle_q <= rel_handle_d;
    end
  end

  // ---------------- shift cycle decode ----------------
  assign hit        = |match_vec;
  assign full       = (live_q == FullCnt);
  assign sel_handle = sel_chain[TABLE_DEPTH];

  always_comb begin
    cmd = CMD_HOLD;
    if (shifting) begin
      case (op_q)
        OP_ADD:        cmd = hit ? CMD_TO_FRONT : CMD_INSERT;
        OP_LOOKUP:     cmd = hit ? CMD_TO_FRONT : CMD_HOLD;
        OP_INVALIDATE: cmd = hit ? CMD_REMOVE : CMD_HOLD;
        default:       cmd = CMD_HOLD;
      endcase
    end
  end

  assign ctrl.cmp_en = accept;
  assign ctrl.cmd    = cmd;

  // a lookup keeps the stored handle, an add writes the new one
  assign front.valid  = 1'b1;
  assign front.key    = key_q;
  assign front.handle = (op_q == OP_LOOKUP) ? sel_handle : handle_q;

  always_comb begin
    hit_d        = 1'b0;
    found_d      = '0;
    rel_valid_d  = 1'b0;
    rel_handle_d = '0;
    live_d       = live_q;
    case (op_q)
      OP_ADD: begin
        hit_d = hit;
        if (hit) begin
          if (sel_handle != handle_q) begin
            rel_valid_d  = 1'b1;
            rel_handle_d = sel_handle;
          end
        end else if (full) begin
          rel_valid_d  = 1'b1;
          rel_handle_d = cell_entry[TABLE_DEPTH-1].handle;
        end else if (shifting) begin
          live_d = live_q + CntW'(1);
        end
      end
      OP_LOOKUP: begin
        hit_d = hit;
        if (hit) begin
          found_d = sel_handle;
        end
      end
      OP_INVALIDATE: begin
        hit_d = hit;
        if (hit && shifting) begin
          live_d = live_q - CntW'(1);
        end
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  // ---------------- cell chain ----------------
  assign seen_chain[0] = 1'b0;
  assign sel_chain[0]  = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign cell_prev[i] = front;
    end else begin : g_body
      assign cell_prev[i] = cell_entry[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      always_comb begin
        cell_next[i]       = cell_entry[i];
        cell_next[i].valid = 1'b0;
      end
    end else begin : g_inner
      assign cell_next[i] = cell_entry[i+1];
    end

    lmtf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .cmp_key_i    (key_i),
      .seen_i       (seen_chain[i]),
      .seen_o       (seen_chain[i+1]),
      .prev_i       (cell_prev[i]),
      .next_i       (cell_next[i]),
      .sel_handle_i (sel_chain[i]),
      .sel_handle_o (sel_chain[i+1]),
      .entry_o      (cell_entry[i]),
      .match_o      (match_vec[i])
    );

    assign valid_vec[i] = cell_entry[i].valid;
  end

  // ---------------- outputs ----------------
  assign result_valid_o    = res_valid_q;
  assign hit_o             = hit_q;
  assign found_handle_o    = found_q;
  assign released_valid_o  = rel_valid_q;
  assign released_handle_o = rel_handle_q;
  assign occupancy_o       = OccW'(live_q);

`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= FullCnt)
    else $error("entry count beyond table depth");

  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(live_q))
    else $error("valid slots disagree with entry count");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shifting |-> $onehot0(match_vec))
    else $error("key matched in more than one slot");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 result_valid_o)
    else $error("request did not produce a result two cycles later");
`endif

endmodule
